@@ hdl/brm_pkg.sv @@
package brm_pkg;

   localparam int MAX_PROCESSES  = 8;
   localparam int RESOURCE_TYPES = 4;
   localparam int COUNT_WIDTH    = 8;
   localparam int COUNT_MAX      = (1 << COUNT_WIDTH) - 1;

   localparam int PID_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int PCNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int WORK_W = COUNT_WIDTH + PCNT_W;

   // item kinds
   localparam logic [2:0] KIND_CLAIM   = 3'd0;
   localparam logic [2:0] KIND_REQUEST = 3'd1;
   localparam logic [2:0] KIND_RELEASE = 3'd2;
   localparam logic [2:0] KIND_END     = 3'd3;
   localparam logic [2:0] KIND_DETECT  = 3'd4;

   // result status
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_AVOID  = 3'd0;
   localparam logic [2:0] CSR_PROCS  = 3'd1;
   localparam logic [2:0] CSR_TYPES  = 3'd2;
   localparam logic [2:0] CSR_EXIST0 = 3'd3;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [RESOURCE_TYPES-1:0][COUNT_WIDTH-1:0] count_vec_type;

   typedef struct packed {
      count_vec_type held;
      count_vec_type claim;
      count_vec_type pend;
   } row_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] proc_id;
      logic [7:0] amount_0;
      logic [7:0] amount_1;
      logic [7:0] amount_2;
      logic [7:0] amount_3;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] stuck_count;
   } rsp_type;

   typedef struct packed {
      logic                                avoidance_on;
      logic [3:0]                          active_processes;
      logic [2:0]                          active_types;
      logic [RESOURCE_TYPES-1:0][7:0]      existing;
   } cfg_type;

   typedef struct packed {
      logic             rd_en;
      logic [PID_W-1:0] rd_addr;
      logic             wr_en;
      logic [PID_W-1:0] wr_addr;
      row_type          wr_data;
   } mem_req_type;

   // clamp an 8-bit field to the count range
   function automatic count_type sat_amt(input logic [7:0] a);
      if (int'(a) > COUNT_MAX) return count_type'(COUNT_MAX);
      return count_type'(a);
   endfunction

   // saturating add of two counts
   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[COUNT_WIDTH]) return '1;
      return s[COUNT_WIDTH-1:0];
   endfunction

endpackage

@@ hdl/bankers_resource_manager.sv @@
// Banker's algorithm resource manager. Each request word (claim, request,
// release, process end or deadlock detection) yields one response word with a
// status (done, wait and retry, error) and, for detection, the count of
// deadlocked processes. Per-process held, claim and pending vectors live in a
// row memory with registered reads; a safety check or detection adds a walk
// over the rows: one row per cycle, passes repeated while rows keep
// finishing. One word is worked at a time; the next is taken while a
// response waits. Write configuration only while the block is idle; writing
// an existing count also reloads that type's available units.
module bankers_resource_manager import brm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type                   cfg_ff;
   logic [RESOURCE_TYPES-1:0] load_ff;
   mem_req_type               mreq;
   row_type                   mem_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.avoidance_on     <= 1'b0;
         cfg_ff.active_processes <= 4'd8;
         cfg_ff.active_types     <= 3'd4;
         cfg_ff.existing         <= '0;
         load_ff                 <= '0;
      end else begin
         load_ff <= '0;
         if (csr_we) begin
            if (csr_index == CSR_AVOID) cfg_ff.avoidance_on <= csr_wdata[0];
            if (csr_index == CSR_PROCS) cfg_ff.active_processes <= csr_wdata[3:0];
            if (csr_index == CSR_TYPES) cfg_ff.active_types <= csr_wdata[2:0];
            for (int k = 0; k < RESOURCE_TYPES; k++) begin
               if (csr_index == CSR_EXIST0 + 3'(k)) begin
                  cfg_ff.existing[k] <= csr_wdata;
                  load_ff[k]         <= 1'b1;
               end
            end
         end
      end
   end

   brm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .avail_load (load_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mreq       (mreq),
      .mem_rdata  (mem_rdata)
   );

   brm_row_mem u_mem (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .rdata (mem_rdata)
   );

endmodule

@@ hdl/brm_row_mem.sv @@
module brm_row_mem import brm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mreq,
   output row_type     rdata
);

   row_type                  mem [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] valid_ff;
   row_type                  raw_ff;
   logic                     rvld_ff;

   // write and read the row store
   always_ff @(posedge clock) begin
      if (mreq.wr_en) begin
         mem[mreq.wr_addr] <= mreq.wr_data;
      end
      if (mreq.rd_en) begin
         raw_ff <= mem[mreq.rd_addr];
      end
   end

   // track rows written since reset; others read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         if (mreq.wr_en) valid_ff[mreq.wr_addr] <= 1'b1;
         if (mreq.rd_en) rvld_ff <= valid_ff[mreq.rd_addr];
      end
   end

   assign rdata = rvld_ff ? raw_ff : '0;

endmodule

@@ hdl/brm_ctrl.sv @@
module brm_ctrl import brm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic [RESOURCE_TYPES-1:0] avail_load,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   output mem_req_type               mreq,
   input  row_type                   mem_rdata
);

   typedef enum logic [2:0] {IDLE, EXEC, SCAN, COMMIT, FINISH} state_type;

   state_type                   state_ff;
   logic [2:0]                  kind_ff;
   logic [2:0]                  pid_ff;
   count_vec_type               amt_ff;
   count_vec_type               avail_ff;
   count_vec_type               avail_new_ff;
   row_type                     row_new_ff;
   row_type                     row_keep_ff;
   logic [1:0]                  status_ff;
   logic                        safety_ff;
   logic [RESOURCE_TYPES-1:0][WORK_W-1:0] work_ff;
   logic [MAX_PROCESSES-1:0]    done_ff;
   logic [PCNT_W-1:0]           left_ff;
   logic [PCNT_W-1:0]           rd_idx_ff;
   logic                        ev_vld_ff;
   logic [PID_W-1:0]            ev_idx_ff;
   logic                        prog_ff;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_data_ff;

   logic [PCNT_W-1:0]           n_c;
   logic [RESOURCE_TYPES-1:0]   tmask_c;
   count_vec_type               req_amt_c;

   row_type                     row_new_c;
   row_type                     row_keep_c;
   count_vec_type               avail_new_c;
   logic [1:0]                  status_c;
   logic                        scan_c;
   logic                        safety_c;
   logic                        over_claim_c;
   logic                        over_avail_c;
   logic                        over_exist_c;
   logic                        rel_bad_c;

   row_type                     ev_row_c;
   count_vec_type               need_c;
   logic                        fits_c;
   logic                        last_c;
   logic                        scan_rd_c;
   logic [RESOURCE_TYPES-1:0][WORK_W-1:0] work_add_c;
   logic                        unsafe_c;

   // effective process count and type mask
   always_comb begin
      if (int'(cfg.active_processes) > MAX_PROCESSES) n_c = PCNT_W'(MAX_PROCESSES);
      else n_c = PCNT_W'(cfg.active_processes);
      for (int k = 0; k < RESOURCE_TYPES; k++) begin
         tmask_c[k] = int'(cfg.active_types) > k;
      end
   end

   // clamp incoming amounts
   always_comb begin
      logic [3:0][7:0] a;
      a = {req_data.amount_3, req_data.amount_2, req_data.amount_1, req_data.amount_0};
      for (int k = 0; k < RESOURCE_TYPES; k++) begin
         req_amt_c[k] = sat_amt(a[k]);
      end
   end

   // decide the item from the row of its process
   always_comb begin
      row_new_c    = mem_rdata;
      row_keep_c   = mem_rdata;
      avail_new_c  = avail_ff;
      status_c     = ST_OK;
      scan_c       = 1'b0;
      safety_c     = 1'b0;
      over_claim_c = 1'b0;
      over_avail_c = 1'b0;
      over_exist_c = 1'b0;
      rel_bad_c    = 1'b0;
      for (int k = 0; k < RESOURCE_TYPES; k++) begin
         if (tmask_c[k]) begin
            if (17'(amt_ff[k]) > 17'(cfg.existing[k])) over_exist_c = 1'b1;
            if (amt_ff[k] > mem_rdata.claim[k]) over_claim_c = 1'b1;
            if (amt_ff[k] > avail_ff[k]) over_avail_c = 1'b1;
            if (mem_rdata.held[k] < amt_ff[k]) rel_bad_c = 1'b1;
            if (17'(avail_ff[k]) + 17'(amt_ff[k]) > 17'(cfg.existing[k])) rel_bad_c = 1'b1;
         end
      end
      priority if (kind_ff == KIND_DETECT) begin
         scan_c = 1'b1;
      end else if (kind_ff > KIND_DETECT || PCNT_W'(pid_ff) >= n_c) begin
         status_c = ST_ERR;
      end else begin
         unique case (kind_ff)
            KIND_CLAIM: begin
               if (!cfg.avoidance_on || over_exist_c) begin
                  status_c = ST_ERR;
               end else begin
                  for (int k = 0; k < RESOURCE_TYPES; k++)
                     if (tmask_c[k]) row_new_c.claim[k] = amt_ff[k];
               end
            end
            KIND_REQUEST: begin
               for (int k = 0; k < RESOURCE_TYPES; k++)
                  if (tmask_c[k]) row_keep_c.pend[k] = amt_ff[k];
               if (cfg.avoidance_on && over_claim_c) begin
                  status_c = ST_ERR;
                  for (int k = 0; k < RESOURCE_TYPES; k++)
                     if (tmask_c[k]) row_new_c.pend[k] = '0;
               end else if (over_avail_c) begin
                  status_c  = ST_WAIT;
                  row_new_c = row_keep_c;
               end else begin
                  for (int k = 0; k < RESOURCE_TYPES; k++) begin
                     if (tmask_c[k]) begin
                        avail_new_c[k]   = avail_ff[k] - amt_ff[k];
                        row_new_c.held[k] = sat_add(mem_rdata.held[k], amt_ff[k]);
                        row_new_c.pend[k] = '0;
                        if (cfg.avoidance_on)
                           row_new_c.claim[k] = mem_rdata.claim[k] - amt_ff[k];
                     end
                  end
                  scan_c   = cfg.avoidance_on;
                  safety_c = cfg.avoidance_on;
               end
            end
            KIND_RELEASE: begin
               if (rel_bad_c) begin
                  status_c = ST_ERR;
               end else begin
                  for (int k = 0; k < RESOURCE_TYPES; k++) begin
                     if (tmask_c[k]) begin
                        row_new_c.held[k] = mem_rdata.held[k] - amt_ff[k];
                        avail_new_c[k]    = sat_add(avail_ff[k], amt_ff[k]);
                        if (cfg.avoidance_on)
                           row_new_c.claim[k] = sat_add(mem_rdata.claim[k], amt_ff[k]);
                     end
                  end
               end
            end
            KIND_END: begin
               for (int k = 0; k < RESOURCE_TYPES; k++) begin
                  if (tmask_c[k]) begin
                     row_new_c.claim[k] = '0;
                     row_new_c.pend[k]  = '0;
                     row_new_c.held[k]  = '0;
                     avail_new_c[k]     = sat_add(avail_ff[k], mem_rdata.held[k]);
                  end
               end
            end
            default: status_c = ST_ERR;
         endcase
      end
   end

   // evaluate one row of the walk
   always_comb begin
      ev_row_c = (ev_idx_ff == pid_ff[PID_W-1:0]) ? row_new_ff : mem_rdata;
      need_c   = safety_ff ? ev_row_c.claim : ev_row_c.pend;
      fits_c   = ev_vld_ff && !done_ff[ev_idx_ff];
      for (int k = 0; k < RESOURCE_TYPES; k++) begin
         if (tmask_c[k] && WORK_W'(need_c[k]) > work_ff[k]) fits_c = 1'b0;
         work_add_c[k] = work_ff[k] + WORK_W'(ev_row_c.held[k]);
      end
      last_c    = ev_vld_ff && (PCNT_W'(ev_idx_ff) == n_c - PCNT_W'(1));
      scan_rd_c = (state_ff == SCAN) && (rd_idx_ff < n_c);
      unsafe_c  = safety_ff && (left_ff != '0);
   end

   // row store port
   always_comb begin
      mreq.rd_en   = (state_ff == IDLE && req_valid) || scan_rd_c;
      mreq.rd_addr = (state_ff == IDLE) ? req_data.proc_id[PID_W-1:0]
                                        : rd_idx_ff[PID_W-1:0];
      mreq.wr_en   = (state_ff == COMMIT);
      mreq.wr_addr = pid_ff[PID_W-1:0];
      mreq.wr_data = unsafe_c ? row_keep_ff : row_new_ff;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         avail_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ev_vld_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != FINISH) rsp_valid_ff <= 1'b0;
         for (int k = 0; k < RESOURCE_TYPES; k++)
            if (avail_load[k]) avail_ff[k] <= sat_amt(cfg.existing[k]);
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_data.kind;
                  pid_ff   <= req_data.proc_id;
                  amt_ff   <= req_amt_c;
                  state_ff <= EXEC;
               end
            end
            EXEC: begin
               row_new_ff   <= row_new_c;
               row_keep_ff  <= row_keep_c;
               avail_new_ff <= avail_new_c;
               status_ff    <= status_c;
               safety_ff    <= safety_c;
               if (scan_c && n_c != '0) begin
                  for (int k = 0; k < RESOURCE_TYPES; k++)
                     work_ff[k] <= WORK_W'(safety_c ? avail_new_c[k] : avail_ff[k]);
                  done_ff   <= '0;
                  left_ff   <= n_c;
                  rd_idx_ff <= '0;
                  prog_ff   <= 1'b0;
                  ev_vld_ff <= 1'b0;
                  state_ff  <= SCAN;
               end else begin
                  left_ff  <= '0;
                  state_ff <= COMMIT;
               end
            end
            SCAN: begin
               ev_vld_ff <= scan_rd_c;
               ev_idx_ff <= rd_idx_ff[PID_W-1:0];
               if (scan_rd_c) rd_idx_ff <= rd_idx_ff + PCNT_W'(1);
               if (fits_c) begin
                  work_ff            <= work_add_c;
                  done_ff[ev_idx_ff] <= 1'b1;
                  left_ff            <= left_ff - PCNT_W'(1);
               end
               // start another pass while rows keep finishing
               if (last_c) begin
                  if (prog_ff || fits_c) begin
                     rd_idx_ff <= '0;
                     prog_ff   <= 1'b0;
                  end else begin
                     state_ff <= COMMIT;
                  end
               end else if (fits_c) begin
                  prog_ff <= 1'b1;
               end
            end
            COMMIT: begin
               if (unsafe_c) begin
                  status_ff <= ST_WAIT;
               end else begin
                  avail_ff <= avail_new_ff;
               end
               state_ff <= FINISH;
            end
            FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.status      <= status_ff;
                  rsp_data_ff.stuck_count <= safety_ff ? 4'd0 : 4'(left_ff);
                  state_ff                <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/brm_checker.sv @@
module brm_checker import brm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input rsp_type    rsp_data
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // status is one of the three codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_WAIT ||
                     rsp_data.status == ST_ERR))
      else $error("bad status code");

   // deadlock count only with a done status and never above the process count
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stuck_count != 4'd0 |->
         rsp_data.status == ST_OK && int'(rsp_data.stuck_count) <= MAX_PROCESSES)
      else $error("bad deadlock count");

   // a word just accepted cannot be answered in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response too early");

endmodule

bind bankers_resource_manager brm_checker u_checker (.*);

@@ dv/tb_bankers_resource_manager.sv @@
`timescale 1ns / 100ps

module tb_bankers_resource_manager;
   import brm_pkg::*;

   localparam logic [2:0] KIND_BAD_LO = 3'd5;
   localparam logic [2:0] KIND_BAD_HI = 3'd7;
   localparam int DRAIN_WAIT = 120;
   localparam int STALL_LIMIT = 8000;
   localparam int HOLD_CYCLES = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   bankers_resource_manager dut (.*);

   // shadow of the block: configuration and bookkeeping
   logic       sh_avoid;
   logic [3:0] sh_procs;
   logic [2:0] sh_types;
   int sh_exist[4];
   int sh_avail[4];
   int sh_held[8][4];
   int sh_claim[8][4];
   int sh_pend[8][4];

   rsp_type expected_rsp[$];
   int  mismatches = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  send_idle = 0;
   int  recv_idle = 0;
   bit  valid_lowered = 1'b1;
   bit  hold_req = 1'b0;
   bit  hold_seen = 1'b0;
   int  hold_cnt = 0;
   int  stall_cnt = 0;

   initial forever #5 clock = ~clock;

   function automatic int sat_count(int v);
      return (v > COUNT_MAX) ? COUNT_MAX : v;
   endfunction

   function automatic int rows_used();
      return (sh_procs > MAX_PROCESSES) ? MAX_PROCESSES : int'(sh_procs);
   endfunction

   function automatic int cols_used();
      return (sh_types > RESOURCE_TYPES) ? RESOURCE_TYPES : int'(sh_types);
   endfunction

   // count rows that never finish; rows are claims or pending requests
   function automatic int count_stuck(bit by_claim, int n, int m);
      int work[4];
      bit done[8];
      int left;
      bit progress;
      bit fits;
      int rowv;
      for (int k = 0; k < 4; k++) work[k] = sh_avail[k];
      for (int i = 0; i < 8; i++) done[i] = 1'b0;
      left = n;
      progress = 1'b1;
      while (progress) begin
         progress = 1'b0;
         for (int i = 0; i < n; i++) begin
            fits = !done[i];
            for (int k = 0; k < m; k++) begin
               rowv = by_claim ? sh_claim[i][k] : sh_pend[i][k];
               if (rowv > work[k]) fits = 1'b0;
            end
            if (fits) begin
               for (int k = 0; k < m; k++) work[k] += sh_held[i][k];
               done[i] = 1'b1;
               left--;
               progress = 1'b1;
            end
         end
      end
      return left;
   endfunction

   // work out the response word and advance the shadow state
   function automatic rsp_type allocate_word(req_type r);
      int amt[4];
      int sa[4], sh[4], sn[4];
      int n, m, p;
      logic [1:0] st;
      int cnt;
      bit fits;
      rsp_type o;
      amt[0] = r.amount_0; amt[1] = r.amount_1;
      amt[2] = r.amount_2; amt[3] = r.amount_3;
      for (int k = 0; k < 4; k++) amt[k] = sat_count(amt[k]);
      n = rows_used();
      m = cols_used();
      p = r.proc_id;
      st = ST_OK;
      cnt = 0;
      if (r.kind == KIND_DETECT) begin
         cnt = count_stuck(1'b0, n, m);
      end else if (r.kind > KIND_DETECT || p >= n) begin
         st = ST_ERR;
      end else if (r.kind == KIND_CLAIM) begin
         if (!sh_avoid) st = ST_ERR;
         for (int k = 0; k < m; k++) if (amt[k] > sh_exist[k]) st = ST_ERR;
         if (st == ST_OK) for (int k = 0; k < m; k++) sh_claim[p][k] = amt[k];
      end else if (r.kind == KIND_REQUEST) begin
         for (int k = 0; k < m; k++) sh_pend[p][k] = amt[k];
         if (sh_avoid)
            for (int k = 0; k < m; k++) if (amt[k] > sh_claim[p][k]) st = ST_ERR;
         if (st == ST_ERR) begin
            for (int k = 0; k < m; k++) sh_pend[p][k] = 0;
         end else begin
            fits = 1'b1;
            for (int k = 0; k < m; k++) if (amt[k] > sh_avail[k]) fits = 1'b0;
            if (!fits) begin
               st = ST_WAIT;
            end else if (sh_avoid) begin
               // tentative grant, then roll back if unsafe
               for (int k = 0; k < m; k++) begin
                  sa[k] = sh_avail[k];
                  sh[k] = sh_held[p][k];
                  sn[k] = sh_claim[p][k];
                  sh_avail[k] -= amt[k];
                  sh_held[p][k] = sat_count(sh_held[p][k] + amt[k]);
                  sh_claim[p][k] -= amt[k];
               end
               if (count_stuck(1'b1, n, m) != 0) begin
                  for (int k = 0; k < m; k++) begin
                     sh_avail[k] = sa[k];
                     sh_held[p][k] = sh[k];
                     sh_claim[p][k] = sn[k];
                  end
                  st = ST_WAIT;
               end else begin
                  for (int k = 0; k < m; k++) sh_pend[p][k] = 0;
               end
            end else begin
               for (int k = 0; k < m; k++) begin
                  sh_avail[k] -= amt[k];
                  sh_held[p][k] = sat_count(sh_held[p][k] + amt[k]);
                  sh_pend[p][k] = 0;
               end
            end
         end
      end else if (r.kind == KIND_RELEASE) begin
         for (int k = 0; k < m; k++) begin
            if (sh_held[p][k] < amt[k]) st = ST_ERR;
            if (sh_avail[k] + amt[k] > sh_exist[k]) st = ST_ERR;
         end
         if (st == ST_OK)
            for (int k = 0; k < m; k++) begin
               sh_held[p][k] -= amt[k];
               if (sh_avoid) sh_claim[p][k] = sat_count(sh_claim[p][k] + amt[k]);
               sh_avail[k] = sat_count(sh_avail[k] + amt[k]);
            end
      end else begin
         for (int k = 0; k < m; k++) begin
            sh_claim[p][k] = 0;
            sh_pend[p][k] = 0;
            sh_avail[k] = sat_count(sh_avail[k] + sh_held[p][k]);
            sh_held[p][k] = 0;
         end
      end
      o.status = st;
      o.stuck_count = cnt[3:0];
      return o;
   endfunction

   // send one request word; valid stays up when the next word follows at once
   task automatic send_word(req_type r);
      if (valid_lowered) begin
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(allocate_word(r));
      words_sent++;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         valid_lowered = 1'b1;
      end else begin
         valid_lowered = 1'b0;
      end
   endtask

   // drop valid and wait for every response plus the block's tail latency
   task automatic wait_quiet();
      if (!valid_lowered) begin
         req_valid <= 1'b0;
         valid_lowered = 1'b1;
      end
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(int idx, int val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx[2:0];
      csr_wdata <= val[7:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AVOID: sh_avoid = val[0];
         CSR_PROCS: sh_procs = val[3:0];
         CSR_TYPES: sh_types = val[2:0];
         default: begin
            sh_exist[idx - CSR_EXIST0] = val[7:0];
            sh_avail[idx - CSR_EXIST0] = sat_count(val[7:0]);
         end
      endcase
   endtask

   task automatic configure(int avoid, int procs, int types, int e0, int e1, int e2, int e3);
      wait_quiet();
      csr_write(CSR_AVOID, avoid);
      csr_write(CSR_PROCS, procs);
      csr_write(CSR_TYPES, types);
      csr_write(CSR_EXIST0 + 0, e0);
      csr_write(CSR_EXIST0 + 1, e1);
      csr_write(CSR_EXIST0 + 2, e2);
      csr_write(CSR_EXIST0 + 3, e3);
   endtask

   function automatic req_type mk(logic [2:0] kind, int p, int a0, int a1, int a2, int a3);
      req_type r;
      r.kind = kind;
      r.proc_id = p[2:0];
      r.amount_0 = a0[7:0];
      r.amount_1 = a1[7:0];
      r.amount_2 = a2[7:0];
      r.amount_3 = a3[7:0];
      return r;
   endfunction

   // mostly well-formed traffic that follows the shadow state, some noise
   function automatic req_type random_word();
      req_type r;
      int amt[4];
      int roll, n, p, hi;
      logic [2:0] kind;
      roll = $urandom_range(99);
      if (roll < 10) begin
         r = mk(3'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         n = rows_used();
         p = (n > 0) ? $urandom_range(n - 1) : $urandom_range(7);
         roll = $urandom_range(99);
         if (sh_avoid && roll < 15) kind = KIND_CLAIM;
         else if (roll < 55) kind = KIND_REQUEST;
         else if (roll < 80) kind = KIND_RELEASE;
         else if (roll < 90) kind = KIND_END;
         else kind = KIND_DETECT;
         for (int k = 0; k < 4; k++) begin
            case (kind)
               KIND_CLAIM:   hi = sh_exist[k];
               KIND_RELEASE: hi = sh_held[p][k];
               KIND_REQUEST: hi = sh_avoid ? sh_claim[p][k] : sat_count(sh_avail[k] + 2);
               default:      hi = 255;
            endcase
            amt[k] = $urandom_range(hi);
         end
         r = mk(kind, p, amt[0], amt[1], amt[2], amt[3]);
      end
      return r;
   endfunction

   // plain allocation: grants, waits, releases, errors, unused types
   task automatic test_plain_directed();
      configure(0, 8, 4, 10, 20, 255, 0);
      send_word(mk(KIND_REQUEST, 0, 5, 5, 5, 0));
      send_word(mk(KIND_REQUEST, 1, 6, 0, 0, 0));
      send_word(mk(KIND_REQUEST, 2, 0, 0, 0, 1));
      send_word(mk(KIND_DETECT, 5, 255, 255, 255, 255));
      send_word(mk(KIND_RELEASE, 0, 6, 0, 0, 0));
      send_word(mk(KIND_RELEASE, 0, 2, 5, 5, 0));
      send_word(mk(KIND_CLAIM, 0, 1, 1, 1, 0));
      send_word(mk(KIND_END, 0, 0, 0, 0, 0));
      send_word(mk(KIND_REQUEST, 7, 10, 20, 255, 0));
      send_word(mk(KIND_END, 7, 0, 0, 0, 0));
      send_word(mk(KIND_BAD_LO, 0, 0, 0, 0, 0));
      send_word(mk(KIND_BAD_HI, 7, 255, 255, 255, 255));
      send_word(mk(KIND_RELEASE, 3, 0, 0, 0, 1));
      configure(0, 3, 2, 255, 1, 0, 0);
      send_word(mk(KIND_REQUEST, 5, 1, 1, 0, 0));
      send_word(mk(KIND_REQUEST, 2, 255, 1, 255, 255));
      send_word(mk(KIND_REQUEST, 1, 1, 1, 0, 0));
      send_word(mk(KIND_DETECT, 0, 0, 0, 0, 0));
   endtask

   // avoidance: claims, claim limits, unsafe requests, deadlock detection
   task automatic test_avoid_directed();
      configure(1, 3, 4, 10, 10, 10, 10);
      send_word(mk(KIND_CLAIM, 0, 8, 8, 8, 8));
      send_word(mk(KIND_CLAIM, 1, 11, 0, 0, 0));
      send_word(mk(KIND_CLAIM, 1, 8, 8, 8, 8));
      send_word(mk(KIND_REQUEST, 0, 9, 0, 0, 0));
      send_word(mk(KIND_REQUEST, 0, 5, 5, 5, 5));
      send_word(mk(KIND_REQUEST, 1, 5, 5, 5, 5));
      send_word(mk(KIND_REQUEST, 1, 2, 2, 2, 2));
      send_word(mk(KIND_DETECT, 0, 0, 0, 0, 0));
      send_word(mk(KIND_RELEASE, 0, 5, 5, 5, 5));
      send_word(mk(KIND_REQUEST, 1, 5, 5, 5, 5));
      send_word(mk(KIND_END, 1, 0, 0, 0, 0));
      send_word(mk(KIND_CLAIM, 3, 1, 1, 1, 1));
      send_word(mk(KIND_DETECT, 2, 0, 0, 0, 0));
   endtask

   // random traffic over a few settings, extremes included
   task automatic test_random(int words, int s_idle, int r_idle);
      int e[4];
      int procs, types;
      send_idle = s_idle;
      recv_idle <= r_idle;
      for (int s = 0; s < 4; s++) begin
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(5))
               0: e[k] = 0;
               1: e[k] = 255;
               default: e[k] = $urandom_range(1, 40);
            endcase
         end
         case (s)
            0: begin procs = 8; types = 4; end
            1: begin procs = 1; types = 1; end
            default: begin
               procs = ($urandom_range(9) == 0) ? 15 : $urandom_range(1, 8);
               types = ($urandom_range(9) == 0) ? 7 : $urandom_range(1, 4);
            end
         endcase
         configure($urandom_range(1), procs, types, e[0], e[1], e[2], e[3]);
         for (int i = 0; i < words / 4; i++) send_word(random_word());
      end
   endtask

   // stall responses for a long stretch while words keep coming
   task automatic test_backpressure();
      configure(0, 8, 4, 30, 30, 30, 30);
      send_idle = 0;
      recv_idle <= 0;
      @(posedge clock);
      hold_req <= ~hold_req;
      for (int i = 0; i < 40; i++) send_word(random_word());
   endtask

   // response side: random idling plus commanded hold-off
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_cnt  <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            if (rsp_data.status !== expected_rsp[0].status ||
                rsp_data.stuck_count !== expected_rsp[0].stuck_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected status %0d count %0d, got %0d %0d",
                           words_checked, expected_rsp[0].status,
                           expected_rsp[0].stuck_count,
                           rsp_data.status, rsp_data.stuck_count);
            end
            void'(expected_rsp.pop_front());
            words_checked++;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we ||
          (expected_rsp.size() == 0 && !req_valid))
         stall_cnt <= 0;
      else
         stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      sh_avoid = 1'b0;
      sh_procs = 4'd8;
      sh_types = 3'd4;
      for (int k = 0; k < 4; k++) begin
         sh_exist[k] = 0;
         sh_avail[k] = 0;
         for (int i = 0; i < 8; i++) begin
            sh_held[i][k] = 0;
            sh_claim[i][k] = 0;
            sh_pend[i][k] = 0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      recv_idle <= 30;
      send_idle = 20;
      test_plain_directed();
      test_avoid_directed();
      test_random(420, 18, 74);
      test_random(420, 74, 18);
      test_random(420, 0, 0);
      test_backpressure();
      wait_quiet();
      if (expected_rsp.size() != 0) mismatches++;
      $display("covered plain and avoidance allocation, claims, releases, process ends,");
      $display("detection and backpressure: %0d words sent, %0d responses checked",
               words_sent, words_checked);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ bankers_resource_manager.f @@
hdl/brm_pkg.sv
hdl/brm_row_mem.sv
hdl/brm_ctrl.sv
hdl/bankers_resource_manager.sv
hdl/brm_checker.sv
dv/tb_bankers_resource_manager.sv
